/* src/sbf_pkg.sv */
// Shared types, codes and helper functions of the ARGB surface blend/fill engine.
package sbf_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int SURFACE_RESET  = 256;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int COLOR_W     = 32;
  localparam int ALPHA_LSB   = 24;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 2'd1;

  localparam logic [2:0] MODE_CLEAR       = 3'd0;
  localparam logic [2:0] MODE_SET_PIXEL   = 3'd1;
  localparam logic [2:0] MODE_BLEND_PIXEL = 3'd2;
  localparam logic [2:0] MODE_BLEND_RECT  = 3'd3;
  localparam logic [2:0] MODE_READ_PIXEL  = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [31:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_color;
    logic [2:0]  done_mode;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_BLEND,
    OP_READ
  } sbf_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_RD,
    ST_WR,
    ST_FIN
  } sbf_state_t;

  // Exact floor(v / 255) for v <= 65025.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(1) + 17'(v[15:8]);
    return t[15:8];
  endfunction

endpackage

/* src/sbf_frame_mem.sv */
// Frame store: one write port and one registered read port.
module sbf_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/sbf_blend_unit.sv */
// Shared source-over blend datapath for one pixel (partial alpha only).
module sbf_blend_unit (
  input  logic [31:0] src_color,
  input  logic [31:0] dst_color,
  output logic [31:0] mix_color
);
  import sbf_pkg::*;

  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;
  logic [15:0] src_term [3];
  logic [15:0] dst_term [3];
  logic [16:0] sum      [3];
  logic [7:0]  chan     [3];

  assign alpha     = src_color[31:ALPHA_LSB];
  assign inv_alpha = ALPHA_OPAQUE - alpha;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      src_term[c] = 16'(src_color[8*c +: 8]) * 16'(alpha);
      dst_term[c] = 16'(dst_color[8*c +: 8]) * 16'(inv_alpha);
      sum[c]      = 17'(src_term[c]) + 17'(dst_term[c]);
      chan[c]     = div255(sum[c][15:0]);
    end
  end

  assign mix_color = {ALPHA_OPAQUE, chan[2], chan[1], chan[0]};

endmodule

/* src/argb_surface_blend_fill_engine_unit.sv */
// Top level: command sequencer, clipping and pixel walker around the frame store.
// Sequence: an accepted command enters ST_SETUP; a skipped command goes on to ST_FIN, a
//   write visits ST_WR for each pixel, a mixed blend or a read visits ST_RD then ST_WR for
//   each pixel, and the out_valid strobe is raised in ST_FIN.
// Overlap: a new command is taken in the strobe cycle, so back-to-back commands need no
//   idle state; each pixel of a walk costs one memory write, preceded by a read when blending.
// Reset: synchronous, active low; afterwards the store is zeroed one word per cycle
//   (all MAX_WIDTH*MAX_HEIGHT words) with busy high. The receiver cannot stall.
module argb_surface_blend_fill_engine_unit #(
  parameter int MAX_WIDTH  = sbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command transaction
  input  logic                            start,
  output logic                            busy,
  input  sbf_pkg::in_item_t               in_data,
  // result transaction
  output logic                            out_valid,
  output sbf_pkg::out_item_t              out_data,
  // register write transaction
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sbf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = 18;  // signed span for origin + extent
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [WW-1:0] W_RESET =
    WW'((SURFACE_RESET > MAX_WIDTH) ? MAX_WIDTH : SURFACE_RESET);
  localparam logic [HW-1:0] H_RESET =
    HW'((SURFACE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SURFACE_RESET);

  // ---------------- registers ----------------
  sbf_state_t     state_r, state_nxt;
  sbf_op_t        op_r, op_nxt;
  logic [2:0]     mode_r, mode_nxt;
  logic [31:0]    color_r, color_nxt;
  logic [31:0]    rd_color_r, rd_color_nxt;
  logic           empty_r, empty_nxt;
  logic [WW-1:0]  x0_r, x0_nxt, x1_r, x1_nxt, cx_r, cx_nxt;
  logic [HW-1:0]  y0_r, y0_nxt, y1_r, y1_nxt, cy_r, cy_nxt;
  logic [AW-1:0]  row_base_r, row_base_nxt;
  logic [AW-1:0]  init_cnt_r, init_cnt_nxt;
  logic [WW-1:0]  surf_w_r, surf_w_nxt;
  logic [HW-1:0]  surf_h_r, surf_h_nxt;

  // ---------------- memory and blend unit ----------------
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, pix_addr;
  logic [31:0]   mem_wdata, mem_rdata, blend_color;

  assign pix_addr = row_base_r + AW'(cx_r);

  sbf_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (pix_addr),
    .rdata (mem_rdata)
  );

  sbf_blend_unit u_blend (
    .src_color (color_r),
    .dst_color (mem_rdata),
    .mix_color (blend_color)
  );

  // ---------------- register port ----------------
  // Writes are always taken; values saturate to 1..MAX.
  assign cfg_ready = 1'b1;

  always_comb begin
    surf_w_nxt = surf_w_r;
    surf_h_nxt = surf_h_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SURFACE_WIDTH: begin
          if (cfg_data == '0) surf_w_nxt = WW'(1);
          else if (32'(cfg_data) > 32'(MAX_WIDTH)) surf_w_nxt = WW'(MAX_WIDTH);
          else surf_w_nxt = WW'(cfg_data);
        end
        CFG_SURFACE_HEIGHT: begin
          if (cfg_data == '0) surf_h_nxt = HW'(1);
          else if (32'(cfg_data) > 32'(MAX_HEIGHT)) surf_h_nxt = HW'(MAX_HEIGHT);
          else surf_h_nxt = HW'(cfg_data);
        end
        default: ;
      endcase
    end
  end

  // ---------------- command decode and clipping ----------------
  // Pixel commands are treated as a 1x1 rectangle, so one clip path covers all.
  logic                 is_rect;
  logic signed [SW-1:0] xs, ys, wsel, hsel, xe, ye, x0s, y0s, x1s, y1s, wlim, hlim;
  logic                 clip_empty;
  logic [7:0]           cmd_alpha;
  sbf_op_t              cmd_op;
  logic                 cmd_empty;
  logic [WW-1:0]        cmd_x0, cmd_x1;
  logic [HW-1:0]        cmd_y0, cmd_y1;

  always_comb begin
    is_rect    = (in_data.mode == MODE_BLEND_RECT);
    xs         = SW'(in_data.x_pos);
    ys         = SW'(in_data.y_pos);
    wsel       = is_rect ? SW'(in_data.rect_width)  : SW'(1);
    hsel       = is_rect ? SW'(in_data.rect_height) : SW'(1);
    xe         = xs + wsel;
    ye         = ys + hsel;
    wlim       = $signed(SW'(surf_w_r));
    hlim       = $signed(SW'(surf_h_r));
    x0s        = xs[SW-1] ? '0 : xs;
    y0s        = ys[SW-1] ? '0 : ys;
    x1s        = (xe > wlim) ? wlim : xe;
    y1s        = (ye > hlim) ? hlim : ye;
    clip_empty = (wsel <= 0) || (hsel <= 0) || (x0s >= x1s) || (y0s >= y1s);
    cmd_alpha  = in_data.color[31:ALPHA_LSB];

    cmd_x0    = x0s[WW-1:0];
    cmd_x1    = x1s[WW-1:0];
    cmd_y0    = y0s[HW-1:0];
    cmd_y1    = y1s[HW-1:0];
    cmd_empty = clip_empty;
    cmd_op    = OP_NONE;
    case (in_data.mode)
      MODE_CLEAR: begin
        cmd_op    = OP_WRITE;
        cmd_empty = 1'b0;
        cmd_x0    = '0;
        cmd_x1    = surf_w_r;
        cmd_y0    = '0;
        cmd_y1    = surf_h_r;
      end
      MODE_SET_PIXEL: cmd_op = OP_WRITE;
      MODE_BLEND_PIXEL, MODE_BLEND_RECT: begin
        // transparent source draws nothing, opaque source is a plain write
        if (cmd_alpha == ALPHA_CLEAR) begin
          cmd_empty = 1'b1;
        end else if (cmd_alpha == ALPHA_OPAQUE) begin
          cmd_op = OP_WRITE;
        end else begin
          cmd_op = OP_BLEND;
        end
      end
      MODE_READ_PIXEL: cmd_op = OP_READ;
      default: cmd_empty = 1'b1;
    endcase
  end

  // ---------------- sequencer ----------------
  logic last_col, last_row;

  assign last_col  = (WW'(cx_r + WW'(1)) == x1_r);
  assign last_row  = (HW'(cy_r + HW'(1)) == y1_r);
  assign busy      = !((state_r == ST_IDLE) || (state_r == ST_FIN));
  assign out_valid = (state_r == ST_FIN);
  assign out_data  = '{read_color: rd_color_r, done_mode: mode_r};

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    mode_nxt     = mode_r;
    color_nxt    = color_r;
    rd_color_nxt = rd_color_r;
    empty_nxt    = empty_r;
    x0_nxt       = x0_r;
    x1_nxt       = x1_r;
    y0_nxt       = y0_r;
    y1_nxt       = y1_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    row_base_nxt = row_base_r;
    init_cnt_nxt = init_cnt_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = pix_addr;
    mem_wdata    = color_r;

    case (state_r)
      ST_INIT: begin
        // zero the store one word per cycle after reset
        mem_we    = 1'b1;
        mem_waddr = init_cnt_r;
        mem_wdata = '0;
        if (init_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          init_cnt_nxt = init_cnt_r + AW'(1);
        end
      end
      ST_IDLE, ST_FIN: begin
        if (start) begin
          op_nxt       = cmd_op;
          mode_nxt     = in_data.mode;
          color_nxt    = in_data.color;
          rd_color_nxt = '0;
          empty_nxt    = cmd_empty;
          x0_nxt       = cmd_x0;
          x1_nxt       = cmd_x1;
          y0_nxt       = cmd_y0;
          y1_nxt       = cmd_y1;
          state_nxt    = ST_SETUP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SETUP: begin
        if (empty_r) begin
          state_nxt = ST_FIN;
        end else begin
          row_base_nxt = AW'(AW'(y0_r) * AW'(surf_w_r));
          cx_nxt       = x0_r;
          cy_nxt       = y0_r;
          state_nxt    = (op_r == OP_WRITE) ? ST_WR : ST_RD;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        case (op_r)
          OP_READ: begin
            rd_color_nxt = mem_rdata;
            state_nxt    = ST_FIN;
          end
          OP_WRITE, OP_BLEND: begin
            mem_we    = 1'b1;
            mem_wdata = (op_r == OP_BLEND) ? blend_color : color_r;
            // step to the next pixel in raster order
            if (!last_col) begin
              cx_nxt    = WW'(cx_r + WW'(1));
              state_nxt = (op_r == OP_BLEND) ? ST_RD : ST_WR;
            end else if (!last_row) begin
              cx_nxt       = x0_r;
              cy_nxt       = HW'(cy_r + HW'(1));
              row_base_nxt = row_base_r + AW'(surf_w_r);
              state_nxt    = (op_r == OP_BLEND) ? ST_RD : ST_WR;
            end else begin
              state_nxt = ST_FIN;
            end
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      init_cnt_r <= '0;
      surf_w_r   <= W_RESET;
      surf_h_r   <= H_RESET;
    end else begin
      state_r    <= state_nxt;
      init_cnt_r <= init_cnt_nxt;
      surf_w_r   <= surf_w_nxt;
      surf_h_r   <= surf_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mode_r     <= mode_nxt;
    color_r    <= color_nxt;
    rd_color_r <= rd_color_nxt;
    empty_r    <= empty_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    row_base_r <= row_base_nxt;
  end

  // ---------------- assertions ----------------
`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not occupy the engine");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> busy)
    else $error("frame store written while engine idle");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the ARGB surface blend/fill engine: directed table, then random.
`timescale 1ns / 1ps

module testbench;
  import sbf_pkg::*;

  // Linear size of the frame store at the default parameters.
  localparam int STORE_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  // Cycles with no transaction of any kind before the run is declared hung. The slowest
  // legal gap is a full-surface blended rectangle, which reads and writes every word; the
  // post-reset zeroing pass writes every word once.
  localparam int STALL_LIMIT = 400000;
  localparam int CMDS_PER_SURFACE = 115;
  localparam int SURFACE_COUNT = 7;
  localparam int MAX_REPORTS = 10;

  // Modes past the defined set; the block must echo them and change nothing.
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // One row of the directed table. A pinned row carries its read_color typed in.
  typedef struct {
    in_item_t    cmd;
    bit          pinned;
    logic [31:0] pinned_color;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the frame store and surface size, kept in step with each accepted transaction.
  logic [31:0] frame_shadow [STORE_WORDS];
  int          surf_w;
  int          surf_h;

  out_item_t   pending_results [$];
  plan_row_t   directed_plan [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cfg_writes = 0;
  int          mode_count [8];
  int          stall_cycles = 0;

  // Surface sizes walked by the random part, written as raw register data. A zero and
  // an oversized value check the saturation of the registers.
  logic [CFG_DATA_W-1:0] phase_w [SURFACE_COUNT] = '{9'd7, 9'd0, 9'd511, 9'd3, 9'd16,
                                                     9'd33, 9'd1};
  logic [CFG_DATA_W-1:0] phase_h [SURFACE_COUNT] = '{9'd5, 9'd0, 9'd2, 9'd256, 9'd16,
                                                     9'd9, 9'd40};

  always #4 clk = ~clk;

  argb_surface_blend_fill_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------------------
  // Pixel math
  // ---------------------------------------------------------------------------------------

  // Source-over on one channel: (src*a + dst*(255-a)) / 255, truncated.
  function automatic logic [7:0] over_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    int full;
    full = int'(ALPHA_OPAQUE);
    return 8'((int'(s) * int'(a) + int'(d) * (full - int'(a))) / full);
  endfunction

  // Transparent source leaves the pixel, opaque source replaces it, anything between
  // mixes the color channels and forces the stored alpha opaque.
  function automatic void blend_word(int idx, logic [31:0] c);
    logic [7:0]  a;
    logic [31:0] d;
    a = c[31:ALPHA_LSB];
    if (a == ALPHA_CLEAR) return;
    if (a == ALPHA_OPAQUE) begin
      frame_shadow[idx] = c;
      return;
    end
    d = frame_shadow[idx];
    frame_shadow[idx] = {ALPHA_OPAQUE, over_channel(c[23:16], d[23:16], a),
                         over_channel(c[15:8], d[15:8], a), over_channel(c[7:0], d[7:0], a)};
  endfunction

  function automatic bit on_surface(int x, int y);
    return x >= 0 && y >= 0 && x < surf_w && y < surf_h;
  endfunction

  // Applies one command to the shadow store and returns the result it must produce.
  function automatic out_item_t apply_command(in_item_t c);
    int        x, y, rw, rh, x0, y0, x1, y1, cx, cy, words;
    out_item_t r;
    x = $signed(c.x_pos);
    y = $signed(c.y_pos);
    rw = $signed(c.rect_width);
    rh = $signed(c.rect_height);
    r.read_color = '0;
    r.done_mode = c.mode;
    case (c.mode)
      MODE_CLEAR: begin
        // Only the active area is painted; words past it keep their old contents.
        words = surf_w * surf_h;
        for (cx = 0; cx < words; cx++) frame_shadow[cx] = c.color;
      end
      MODE_SET_PIXEL: begin
        if (on_surface(x, y)) frame_shadow[y * surf_w + x] = c.color;
      end
      MODE_BLEND_PIXEL: begin
        if (on_surface(x, y)) blend_word(y * surf_w + x, c.color);
      end
      MODE_BLEND_RECT: begin
        // Clip to the surface; an empty or negative extent draws nothing.
        if (rw > 0 && rh > 0) begin
          x0 = (x < 0) ? 0 : x;
          y0 = (y < 0) ? 0 : y;
          x1 = x + rw;
          y1 = y + rh;
          if (x1 > surf_w) x1 = surf_w;
          if (y1 > surf_h) y1 = surf_h;
          for (cy = y0; cy < y1; cy++)
            for (cx = x0; cx < x1; cx++) blend_word(cy * surf_w + cx, c.color);
        end
      end
      MODE_READ_PIXEL: begin
        if (on_surface(x, y)) r.read_color = frame_shadow[y * surf_w + x];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Register writes saturate to 1..MAX; unknown indexes are dropped.
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    int dim;
    dim = (v == 0) ? 1 : int'(v);
    case (idx)
      CFG_SURFACE_WIDTH:  surf_w = (dim > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : dim;
      CFG_SURFACE_HEIGHT: surf_h = (dim > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : dim;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic in_item_t make_cmd(logic [2:0] mode, int x, int y, int rw, int rh,
                                        logic [31:0] color);
    in_item_t c;
    c.mode = mode;
    c.x_pos = 16'(x);
    c.y_pos = 16'(y);
    c.rect_width = 16'(rw);
    c.rect_height = 16'(rh);
    c.color = color;
    return c;
  endfunction

  task automatic add_row(logic [2:0] mode, int x, int y, int rw, int rh, logic [31:0] color,
                         bit pinned, logic [31:0] pinned_color);
    plan_row_t row;
    row.cmd = make_cmd(mode, x, y, rw, rh, color);
    row.pinned = pinned;
    row.pinned_color = pinned_color;
    directed_plan.push_back(row);
  endtask

  // Mostly near the surface (up to two off the low edge, one off the high edge), now and then anywhere in 16 bits.
  function automatic int pick_coord(int dim);
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom));
    return int'($urandom_range(0, dim + 2)) - 2;
  endfunction

  function automatic int pick_extent(int dim);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return $signed(16'($urandom));
    if (roll == 1) return -int'($urandom_range(0, 2));
    return int'($urandom_range(1, dim + 2));
  endfunction

  // Alpha split three ways so copy, skip and mix paths all see plenty of traffic.
  function automatic logic [31:0] pick_color();
    logic [7:0] a;
    case ($urandom_range(0, 2))
      0:       a = ALPHA_CLEAR;
      1:       a = ALPHA_OPAQUE;
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  function automatic in_item_t random_command();
    int         roll;
    logic [2:0] mode;
    roll = $urandom_range(0, 99);
    if (roll < 4)       mode = MODE_CLEAR;
    else if (roll < 26) mode = MODE_SET_PIXEL;
    else if (roll < 48) mode = MODE_BLEND_PIXEL;
    else if (roll < 66) mode = MODE_BLEND_RECT;
    else if (roll < 94) mode = MODE_READ_PIXEL;
    else if (roll < 96) mode = MODE_SPARE_5;
    else if (roll < 98) mode = MODE_SPARE_6;
    else                mode = MODE_SPARE_7;
    return make_cmd(mode, pick_coord(surf_w), pick_coord(surf_h), pick_extent(surf_w),
                    pick_extent(surf_h), pick_color());
  endfunction

  // ---------------------------------------------------------------------------------------
  // Drivers. All inputs change by NBA at the rising edge; start is left high on return
  // so the next command can follow with no bubble.
  // ---------------------------------------------------------------------------------------

  task automatic issue_command(in_item_t c, bit pinned, logic [31:0] pinned_color);
    out_item_t want;
    start <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy);
    // Accepted at this edge: advance the shadow and queue what the block owes us.
    want = apply_command(c);
    if (pinned) want.read_color = pinned_color;
    pending_results.push_back(want);
    mode_count[c.mode]++;
  endtask

  // Idle burst; garbage on in_data must be ignored while start is low.
  task automatic sender_gap(int cycles);
    in_item_t junk;
    junk = {3'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
    start <= 1'b0;
    in_data <= junk;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every outstanding result is back, plus a short settle.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, v);
    cfg_writes++;
  endtask

  // Resize only with the block idle; optionally poke an index that does not exist.
  task automatic configure_surface(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                                   bit poke_spare, logic [CFG_IDX_W-1:0] spare);
    drain_results();
    write_register(CFG_SURFACE_WIDTH, w);
    write_register(CFG_SURFACE_HEIGHT, h);
    if (poke_spare) write_register(spare, 9'($urandom));
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking: every strobe pops the oldest expectation, fields compared one by one.
  // ---------------------------------------------------------------------------------------

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] result %0d: %s expected %h, got %h", $time, results_seen, what, want, got);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, read_color", '0, out_data.read_color);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_color !== want.read_color)
          flag_mismatch("read_color", want.read_color, out_data.read_color);
        if (out_data.done_mode !== want.done_mode)
          flag_mismatch("done_mode", 32'(want.done_mode), 32'(out_data.done_mode));
      end
    end
  end

  // Watchdog: any command, result or register transaction resets the count.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    int i, p, k;
    for (i = 0; i < STORE_WORDS; i++) frame_shadow[i] = '0;
    for (i = 0; i < 8; i++) mode_count[i] = 0;
    surf_w = SURFACE_RESET;
    surf_h = SURFACE_RESET;

    // Directed table at the reset size (256 x 256). Reads right after reset, outside
    // coordinates, alpha skip/copy and unused modes have their answer typed in; mixed
    // blends are left to the shadow model.
    add_row(MODE_READ_PIXEL, 0, 0, 0, 0, 32'h0, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 255, 255, 0, 0, 32'h0, 1'b1, 32'h0);
    add_row(MODE_SET_PIXEL, 255, 255, 0, 0, 32'h12345678, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 255, 255, 0, 0, 32'h0, 1'b1, 32'h12345678);
    // writes just off the left, right and bottom edges must be dropped
    add_row(MODE_SET_PIXEL, -1, 0, 0, 0, 32'hFFFFFFFF, 1'b1, 32'h0);
    add_row(MODE_SET_PIXEL, 256, 0, 0, 0, 32'hFFFFFFFF, 1'b1, 32'h0);
    add_row(MODE_SET_PIXEL, 0, 256, 0, 0, 32'hFFFFFFFF, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, -32768, 32767, 32767, -32768, 32'hFFFFFFFF, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 32767, -32768, -32768, 32767, 32'h0, 1'b1, 32'h0);
    // transparent blend is a no-op, opaque blend is a plain copy
    add_row(MODE_BLEND_PIXEL, 0, 0, 0, 0, 32'h00FFFFFF, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 0, 0, 0, 0, 32'h0, 1'b1, 32'h0);
    add_row(MODE_BLEND_PIXEL, 0, 0, 0, 0, 32'hFFABCDEF, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 0, 0, 0, 0, 32'h0, 1'b1, 32'hFFABCDEF);
    add_row(MODE_BLEND_PIXEL, 0, 0, 0, 0, 32'h80000000, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 0, 0, 0, 0, 32'h0, 1'b0, 32'h0);
    // rectangle hanging off the top-left corner, then empty and degenerate extents
    add_row(MODE_BLEND_RECT, -3, -3, 8, 8, 32'h7F102030, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 4, 4, 0, 0, 32'h0, 1'b0, 32'h0);
    add_row(MODE_BLEND_RECT, 10, 10, 0, 5, 32'hFF00FF00, 1'b1, 32'h0);
    add_row(MODE_BLEND_RECT, 10, 10, -32768, 32767, 32'hFF00FF00, 1'b1, 32'h0);
    add_row(MODE_BLEND_RECT, -32768, -32768, 32767, 32767, 32'hFF00FF00, 1'b1, 32'h0);
    // huge rectangle clipped to the bottom-right corner
    add_row(MODE_BLEND_RECT, 250, 254, 32767, 32767, 32'hC0FEDCBA, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 255, 255, 0, 0, 32'h0, 1'b0, 32'h0);
    add_row(MODE_SPARE_5, 1, 1, 1, 1, 32'hFFFFFFFF, 1'b1, 32'h0);
    add_row(MODE_SPARE_6, 0, 0, 0, 0, 32'h0, 1'b1, 32'h0);
    add_row(MODE_SPARE_7, 255, 255, 1, 1, 32'hFFFFFFFF, 1'b1, 32'h0);
    // full-surface clear: the one long command of the run
    add_row(MODE_CLEAR, 0, 0, 0, 0, 32'hDEADBEEF, 1'b1, 32'h0);
    add_row(MODE_READ_PIXEL, 128, 77, 0, 0, 32'h0, 1'b1, 32'hDEADBEEF);

    // Synchronous reset, then the block zeroes the store with busy high.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i])
      issue_command(directed_plan[i].cmd, directed_plan[i].pinned, directed_plan[i].pinned_color);

    // Random part over small surfaces so clears and rectangles stay cheap; the store
    // keeps its old contents across a resize, exactly as the shadow does.
    for (p = 0; p < SURFACE_COUNT; p++) begin
      configure_surface(phase_w[p], phase_h[p], p == 1 || p == 4,
                        (p == 1) ? CFG_SPARE_2 : CFG_SPARE_3);
      for (k = 0; k < CMDS_PER_SURFACE; k++) begin
        // The last surface runs with start held high throughout.
        if (p != SURFACE_COUNT - 1) begin
          if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 6));
          else if ($urandom_range(0, 49) == 0) drain_results();
        end
        issue_command(random_command(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);

    $write("covered %0d commands: ",
           mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3] + mode_count[4] +
           mode_count[5] + mode_count[6] + mode_count[7]);
    $display("%0d clear, %0d set, %0d blend, %0d rectangle, %0d read, %0d unused mode",
             mode_count[MODE_CLEAR], mode_count[MODE_SET_PIXEL],
             mode_count[MODE_BLEND_PIXEL], mode_count[MODE_BLEND_RECT],
             mode_count[MODE_READ_PIXEL],
             mode_count[MODE_SPARE_5] + mode_count[MODE_SPARE_6] + mode_count[MODE_SPARE_7]);
    $display("%0d results checked over %0d surface sizes, %0d register writes, %0d mismatches",
             results_seen, SURFACE_COUNT + 1, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
